// ===== rtl/core/xsort_pkg.sv =====
// Shared constants and payload types for the exchange sort engine.
package xsort_pkg;

    localparam int DEPTH  = 64;
    localparam int DATA_W = 32;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     last_in;
    } in_item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] sorted_value;
        logic                     last_out;
        logic                     overflow;
    } out_item_t;

endpackage

// ===== rtl/core/xsort_ram.sv =====
// Simple dual-port RAM with one write port and one registered read port.
module xsort_ram #(
    parameter int WIDTH   = 32,
    parameter int AWIDTH  = 6,
    parameter int ENTRIES = 64
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [AWIDTH-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [AWIDTH-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [ENTRIES];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // A read of the address being written returns the old contents.
    always_ff @(posedge aclk) begin
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/core/exchange_sort_engine.sv =====
// Top level of the exchange sort engine: collect, in-memory sort and drain.
//
// Usage: signed 32-bit values arrive on the s_ channel, one per transfer, and
// are written into a 64-entry store. A transfer with last_in set closes the
// set. Values that arrive once the store is full are discarded and every
// result of that set carries overflow. The block then sorts the store in
// place and returns the n stored values in ascending order on the m_ channel,
// with last_out on the final one, after which s_ready rises for the next set.
//
// Timing: collection accepts one input transfer per cycle. The sort is bound
// by the single read port of the store: each compare needs one read. The
// drain reads each result from the store into the output register, and the
// next result is loaded only after the receiver has taken the current one.
// s_ready is low from the closing transfer until the final result is taken.
// A stalled receiver simply holds the current result in the output register.
// Reset (aresetn low at a clock edge) empties the store and clears the
// overflow flag; the store contents themselves are not cleared.
module exchange_sort_engine (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  xsort_pkg::in_item_t   s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output xsort_pkg::out_item_t  m_data
);

    localparam int AW = xsort_pkg::ADDR_W;
    localparam int CW = xsort_pkg::CNT_W;
    localparam int DW = xsort_pkg::DATA_W;

    typedef enum logic [2:0] {
        COLLECT,
        LOAD_PIVOT,
        TAKE_PIVOT,
        SCAN,
        WRITE_PIVOT,
        OUT_READ,
        OUT_LOAD,
        OUT_HOLD
    } state_t;

    state_t               state_reg, state_next;
    logic [CW-1:0]        count_reg, count_next;
    logic                 dropped_reg, dropped_next;
    logic [AW-1:0]        p_reg, p_next;
    logic [CW-1:0]        q_reg, q_next;
    logic [AW-1:0]        cmp_q_reg, cmp_q_next;
    logic                 cmp_valid_reg, cmp_valid_next;
    logic signed [DW-1:0] pivot_reg, pivot_next;
    logic [AW-1:0]        k_reg, k_next;
    logic                 m_valid_reg, m_valid_next;
    xsort_pkg::out_item_t m_data_reg, m_data_next;

    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [DW-1:0]        ram_wdata;
    logic [AW-1:0]        ram_raddr;
    logic [DW-1:0]        ram_rdata;
    logic signed [DW-1:0] rd_value;
    logic [CW-1:0]        fill_count;
    logic                 has_room;

    xsort_ram #(
        .WIDTH   (DW),
        .AWIDTH  (AW),
        .ENTRIES (xsort_pkg::DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_value   = $signed(ram_rdata);
    assign has_room   = (count_reg < CW'(xsort_pkg::DEPTH));
    assign fill_count = has_room ? count_reg + CW'(1) : count_reg;

    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        dropped_next   = dropped_reg;
        p_next         = p_reg;
        q_next         = q_reg;
        cmp_q_next     = cmp_q_reg;
        cmp_valid_next = cmp_valid_reg;
        pivot_next     = pivot_reg;
        k_next         = k_reg;
        m_valid_next   = m_valid_reg;
        m_data_next    = m_data_reg;
        ram_we         = 1'b0;
        ram_waddr      = count_reg[AW-1:0];
        ram_wdata      = s_data.value;
        ram_raddr      = p_reg;

        case (state_reg)
            COLLECT: begin
                if (s_valid) begin
                    if (has_room) begin
                        ram_we     = 1'b1;
                        count_next = fill_count;
                    end else begin
                        dropped_next = 1'b1;
                    end
                    if (s_data.last_in) begin
                        p_next = '0;
                        k_next = '0;
                        if (fill_count >= CW'(2)) begin
                            state_next = LOAD_PIVOT;
                        end else begin
                            state_next = OUT_READ;
                        end
                    end
                end
            end
            LOAD_PIVOT: begin
                ram_raddr  = p_reg;
                state_next = TAKE_PIVOT;
            end
            TAKE_PIVOT: begin
                pivot_next     = rd_value;
                ram_raddr      = p_reg + AW'(1);
                cmp_q_next     = p_reg + AW'(1);
                cmp_valid_next = 1'b1;
                q_next         = CW'(p_reg) + CW'(2);
                state_next     = SCAN;
            end
            SCAN: begin
                // The earlier position's value lives in pivot_reg; a swap
                // writes it to the later entry and keeps the smaller one.
                if (cmp_valid_reg && (pivot_reg > rd_value)) begin
                    ram_we     = 1'b1;
                    ram_waddr  = cmp_q_reg;
                    ram_wdata  = pivot_reg;
                    pivot_next = rd_value;
                end
                ram_raddr = q_reg[AW-1:0];
                if (q_reg < count_reg) begin
                    cmp_valid_next = 1'b1;
                    cmp_q_next     = q_reg[AW-1:0];
                    q_next         = q_reg + CW'(1);
                end else begin
                    cmp_valid_next = 1'b0;
                    state_next     = WRITE_PIVOT;
                end
            end
            WRITE_PIVOT: begin
                ram_we    = 1'b1;
                ram_waddr = p_reg;
                ram_wdata = pivot_reg;
                p_next    = p_reg + AW'(1);
                if (CW'(p_reg) + CW'(2) < count_reg) begin
                    state_next = LOAD_PIVOT;
                end else begin
                    state_next = OUT_READ;
                end
            end
            OUT_READ: begin
                ram_raddr  = k_reg;
                state_next = OUT_LOAD;
            end
            OUT_LOAD: begin
                m_data_next.sorted_value = rd_value;
                m_data_next.last_out     = (CW'(k_reg) + CW'(1) == count_reg);
                m_data_next.overflow     = dropped_reg;
                m_valid_next             = 1'b1;
                state_next               = OUT_HOLD;
            end
            OUT_HOLD: begin
                ram_raddr = k_reg + AW'(1);
                if (m_ready) begin
                    m_valid_next = 1'b0;
                    if (m_data_reg.last_out) begin
                        count_next   = '0;
                        dropped_next = 1'b0;
                        state_next   = COLLECT;
                    end else begin
                        k_next     = k_reg + AW'(1);
                        state_next = OUT_LOAD;
                    end
                end
            end
            default: begin
                state_next = COLLECT;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= COLLECT;
            count_reg     <= '0;
            dropped_reg   <= 1'b0;
            cmp_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            dropped_reg   <= dropped_next;
            cmp_valid_reg <= cmp_valid_next;
            m_valid_reg   <= m_valid_next;
        end
        p_reg      <= p_next;
        q_reg      <= q_next;
        cmp_q_reg  <= cmp_q_next;
        pivot_reg  <= pivot_next;
        k_reg      <= k_next;
        m_data_reg <= m_data_next;
    end

    assign s_ready = (state_reg == COLLECT);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== rtl/core/xsort_checker.sv =====
// Port-level assertions for the exchange sort engine, bound to the top level.
module xsort_checker (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_valid,
    input logic                 s_ready,
    input xsort_pkg::in_item_t  s_data,
    input logic                 m_valid,
    input logic                 m_ready,
    input xsort_pkg::out_item_t m_data
);

    // A result that waits for the receiver holds its contents.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("stalled result changed or dropped");

    // Collection and draining never overlap.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input accepted while a result is pending");

    // After reset the block waits for a new set.
    assert property (@(posedge aclk)
        !aresetn |=> (s_ready && !m_valid))
        else $error("block not ready after reset");

    // A transfer that does not close the set leaves the block collecting.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && !s_data.last_in) |=> s_ready)
        else $error("block left collection without a closing element");

    // The final result of a run returns the block to collection.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_data.last_out) |=> (s_ready && !m_valid))
        else $error("block not ready after the final result");

endmodule

bind exchange_sort_engine xsort_checker u_xsort_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
